>>> hw/rtl/escaped_frame_receiver_crc32_core_macros.svh
// assertion macros used by the frame receiver rtl
`ifndef ESCAPED_FRAME_RECEIVER_CRC32_CORE_MACROS_SVH
`define ESCAPED_FRAME_RECEIVER_CRC32_CORE_MACROS_SVH

// property checked on every rising clock edge outside reset
`define EFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define EFR_NEVER(lbl, cond, msg) \
  `EFR_ASSERT(lbl, !(cond), msg)

`endif

>>> hw/rtl/efr_crc_pkg.sv
// package with types and constants of the escaped frame receiver
`default_nettype none
package efr_crc_pkg;

  localparam int unsigned PAYLOAD_LEN = 13;
  localparam int unsigned FRAME_BYTES = PAYLOAD_LEN + 4;
  localparam int unsigned FILL_W      = $clog2(FRAME_BYTES + 1);
  localparam int unsigned IDX_W       = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;

  localparam logic [7:0]  MARK_HEAD = 8'hAE;
  localparam logic [7:0]  MARK_TAIL = 8'hA5;
  localparam logic [7:0]  MARK_ESC  = 8'hAA;
  localparam logic [7:0]  ESC_HEAD  = 8'h0E;
  localparam logic [7:0]  ESC_TAIL  = 8'h05;
  localparam logic [7:0]  ESC_ESC   = 8'h0A;
  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;

  typedef enum logic [2:0] {
    KIND_PAYLOAD    = 3'd0,
    KIND_BAD_ESC    = 3'd1,
    KIND_STRAY_TAIL = 3'd2,
    KIND_STRAY_HEAD = 3'd3,
    KIND_NO_TAIL    = 3'd4,
    KIND_CRC_BAD    = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_DATA = 2'd1,
    PH_ESC  = 2'd2,
    PH_TAIL = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DECODE = 2'd1,
    ST_CRC    = 2'd2,
    ST_REPLAY = 2'd3
  } state_e;

endpackage
`default_nettype wire

>>> hw/rtl/escaped_frame_receiver_crc32_core.sv
// byte-stuffed frame receiver with crc-32 check, top level
//
// channel   dir  tdata                              tuser      tlast
// s_axis    in   [7:0] rx_byte                      -          -
// m_axis    out  [7:0] payload_byte, [11:8] index   [2:0] kind last
//
// a received word is latched in the idle state and decoded in the decode state;
// a payload word then passes through the bit-serial crc shifter (one bit per
// cycle) before the next word is accepted.
// a good trailer replays the stored payload, one word per cycle while the
// output is not stalled; a stalled output holds the sequencer.
// reset (rst_ni low, asynchronous) returns to the header hunt, crc all ones.
`default_nettype none
`include "escaped_frame_receiver_crc32_core_macros.svh"
module escaped_frame_receiver_crc32_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input words
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  // result words
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [7:0] payload_byte, [11:8] byte_index, rest 0
  output logic [2:0]       m_axis_tuser_o,   // [2:0] kind
  output logic             m_axis_tlast_o
);
  import efr_crc_pkg::*;

  // sequencer and frame state
  state_e              state_q, state_d;
  phase_e              phase_q, phase_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [31:0]         rx_check_q, rx_check_d;
  logic [31:0]         crc_q, crc_d;
  logic [2:0]          bit_cnt_q, bit_cnt_d;
  logic [IDX_W-1:0]    rep_idx_q, rep_idx_d;

  // latched input word and payload store
  logic [7:0]          byte_q;
  logic [7:0]          store_q [PAYLOAD_LEN];
  logic                store_we;
  logic [IDX_W-1:0]    store_wa;
  logic [7:0]          store_wd;

  // output register
  logic                ovalid_q, ovalid_d;
  kind_e               okind_q, okind_d;
  logic [7:0]          obyte_q, obyte_d;
  logic [3:0]          oidx_q, oidx_d;
  logic                olast_q, olast_d;

  logic                out_free;
  logic                take;       // decoded word goes into the frame
  logic [7:0]          take_v;
  logic                emit;       // decoded word raises a status word
  kind_e               emit_kind;

  // output register can be loaded this cycle
  assign out_free = !ovalid_q || m_axis_tready_i;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {4'd0, oidx_q, obyte_q};
  assign m_axis_tuser_o  = okind_q;
  assign m_axis_tlast_o  = olast_q;

  // classify the latched word against the framing phase
  always_comb begin
    take      = 1'b0;
    take_v    = byte_q;
    emit      = 1'b0;
    emit_kind = KIND_BAD_ESC;
    case (phase_q)
      PH_DATA: begin
        if (byte_q == MARK_TAIL) begin
          emit      = 1'b1;
          emit_kind = KIND_STRAY_TAIL;
        end else if (byte_q == MARK_HEAD) begin
          emit      = 1'b1;
          emit_kind = KIND_STRAY_HEAD;
        end else if (byte_q != MARK_ESC) begin
          take = 1'b1;
        end
      end
      PH_ESC: begin
        if (byte_q == ESC_HEAD) begin
          take   = 1'b1;
          take_v = MARK_HEAD;
        end else if (byte_q == ESC_TAIL) begin
          take   = 1'b1;
          take_v = MARK_TAIL;
        end else if (byte_q == ESC_ESC) begin
          take   = 1'b1;
          take_v = MARK_ESC;
        end else begin
          emit      = 1'b1;
          emit_kind = KIND_BAD_ESC;
        end
      end
      PH_TAIL: begin
        if (byte_q != MARK_TAIL) begin
          emit      = 1'b1;
          emit_kind = KIND_NO_TAIL;
        end else if ((crc_q ^ CRC_INIT) != rx_check_q) begin
          emit      = 1'b1;
          emit_kind = KIND_CRC_BAD;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer: next state, frame state and output register
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    fill_d     = fill_q;
    rx_check_d = rx_check_q;
    crc_d      = crc_q;
    bit_cnt_d  = bit_cnt_q;
    rep_idx_d  = rep_idx_q;
    store_we   = 1'b0;
    store_wa   = fill_q[IDX_W-1:0];
    store_wd   = take_v;
    ovalid_d   = ovalid_q && !m_axis_tready_i;
    okind_d    = okind_q;
    obyte_d    = obyte_q;
    oidx_d     = oidx_q;
    olast_d    = olast_q;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = ST_DECODE;
        end
      end

      ST_DECODE: begin
        if (emit) begin
          // status word waits here until the output register is free
          if (out_free) begin
            ovalid_d = 1'b1;
            okind_d  = emit_kind;
            obyte_d  = 8'd0;
            oidx_d   = 4'd0;
            olast_d  = 1'b1;
            phase_d  = PH_HUNT;
            state_d  = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
          case (phase_q)
            PH_HUNT: begin
              if (byte_q == MARK_HEAD) begin
                phase_d    = PH_DATA;
                fill_d     = '0;
                rx_check_d = '0;
                crc_d      = CRC_INIT;
              end
            end
            PH_DATA, PH_ESC: begin
              if (take) begin
                if (fill_q < FILL_W'(PAYLOAD_LEN)) begin
                  store_we  = 1'b1;
                  crc_d     = {crc_q[31:8], crc_q[7:0] ^ take_v};
                  bit_cnt_d = '0;
                  state_d   = ST_CRC;
                end else begin
                  // check bytes arrive low byte first
                  rx_check_d = {take_v, rx_check_q[31:8]};
                end
                fill_d  = fill_q + FILL_W'(1);
                phase_d = (fill_q + FILL_W'(1) >= FILL_W'(FRAME_BYTES)) ? PH_TAIL : PH_DATA;
              end else begin
                // escape marker seen
                phase_d = PH_ESC;
              end
            end
            default: begin
              // good trailer and matching crc
              phase_d   = PH_HUNT;
              rep_idx_d = '0;
              state_d   = ST_REPLAY;
            end
          endcase
        end
      end

      ST_CRC: begin
        // one bit of the reflected crc per cycle
        crc_d     = crc_q[0] ? ((crc_q >> 1) ^ CRC_POLY) : (crc_q >> 1);
        bit_cnt_d = bit_cnt_q + 3'd1;
        if (bit_cnt_q == 3'd7) begin
          state_d = ST_IDLE;
        end
      end

      ST_REPLAY: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          okind_d  = KIND_PAYLOAD;
          obyte_d  = store_q[rep_idx_q];
          oidx_d   = 4'(rep_idx_q);
          olast_d  = (rep_idx_q == IDX_W'(PAYLOAD_LEN - 1));
          if (rep_idx_q == IDX_W'(PAYLOAD_LEN - 1)) begin
            state_d = ST_IDLE;
          end else begin
            rep_idx_d = rep_idx_q + IDX_W'(1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      fill_q     <= '0;
      rx_check_q <= '0;
      crc_q      <= CRC_INIT;
      bit_cnt_q  <= '0;
      rep_idx_q  <= '0;
      ovalid_q   <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      fill_q     <= fill_d;
      rx_check_q <= rx_check_d;
      crc_q      <= crc_d;
      bit_cnt_q  <= bit_cnt_d;
      rep_idx_q  <= rep_idx_d;
      ovalid_q   <= ovalid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      byte_q <= s_axis_tdata_i;
    end
    if (store_we) begin
      store_q[store_wa] <= store_wd;
    end
    okind_q <= okind_d;
    obyte_q <= obyte_d;
    oidx_q  <= oidx_d;
    olast_q <= olast_d;
  end

  // crc shifting only happens right after a payload byte was stored
  `EFR_ASSERT(a_crc_in_data, (state_q == ST_CRC) |-> (phase_q == PH_DATA), "crc shift outside data phase")
  // replay starts only after the frame has been closed
  `EFR_ASSERT(a_replay_hunt, (state_q == ST_REPLAY) |-> (phase_q == PH_HUNT), "replay while frame open")
  // fill count never passes the frame length
  `EFR_NEVER(a_fill_range, fill_q > FILL_W'(FRAME_BYTES), "fill count past frame length")
  // status words always close their input word
  `EFR_ASSERT(a_status_last, (ovalid_q && (okind_q != KIND_PAYLOAD)) |-> olast_q, "status word without last")

endmodule
`default_nettype wire
